FILE: hdl/serial_frame_deframer_checksum_defines.svh
// -----------------------------------------------------------------------------
// Serial frame deframer: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_CHECKSUM_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_CHECKSUM_DEFINES_SVH

`ifndef SYNTHESIS
`define SFDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFDC_ASSERT(label, clk, rst_n, prop, msg)
`define SFDC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: hdl/sfd_pkg.sv
// -----------------------------------------------------------------------------
// Serial frame deframer: package
// Types, codes and the known-command decode shared by the deframer files.
// -----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RoleW   = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] MinLength    = 8'd4;
  localparam logic [ByteW-1:0] HdrFirstRst  = 8'h55;
  localparam logic [ByteW-1:0] HdrSecondRst = 8'hAA;
  localparam logic [ByteW-1:0] EndMarkRst   = 8'hEE;

  typedef enum logic [3:0] {
    PH_HDR1  = 4'd0,
    PH_HDR2  = 4'd1,
    PH_LEN   = 4'd2,
    PH_CMD   = 4'd3,
    PH_FUNC  = 4'd4,
    PH_CHAN  = 4'd5,
    PH_PARAM = 4'd6,
    PH_CSUM  = 4'd7,
    PH_END   = 4'd8
  } phase_e;

  typedef enum logic [RoleW-1:0] {
    ROLE_HDR1    = 4'd0,
    ROLE_HDR2    = 4'd1,
    ROLE_LEN     = 4'd2,
    ROLE_CMD     = 4'd3,
    ROLE_FUNC    = 4'd4,
    ROLE_CHAN    = 4'd5,
    ROLE_PARAM   = 4'd6,
    ROLE_CSUM    = 4'd7,
    ROLE_END     = 4'd8,
    ROLE_DISCARD = 4'd9
  } role_e;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY     = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_FORMAT   = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HDR1 = 2'd0,
    CFG_HDR2 = 2'd1,
    CFG_END  = 2'd2
  } cfg_idx_e;

  function automatic logic cmd_known(input logic [ByteW-1:0] c);
    cmd_known = (c >= 8'h01 && c <= 8'h09) || c == 8'h10 || c == 8'h11 || c == 8'hFF;
  endfunction

endpackage

FILE: hdl/sfd_rx_if.sv
// -----------------------------------------------------------------------------
// Serial frame deframer: receive byte channel
// Valid/ready channel carrying one received byte per beat.
// -----------------------------------------------------------------------------
interface sfd_rx_if;
  import sfd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/sfd_res_if.sv
// -----------------------------------------------------------------------------
// Serial frame deframer: result channel
// Valid/ready channel carrying one tagged byte and frame status per beat.
// -----------------------------------------------------------------------------
interface sfd_res_if;
  import sfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   byte_value;
  logic [RoleW-1:0]   byte_role;
  logic [ByteW-1:0]   param_index;
  logic               frame_done;
  logic [StatusW-1:0] frame_status;

  modport source (output valid, output byte_value, output byte_role, output param_index,
                  output frame_done, output frame_status, input ready);
  modport sink   (input valid, input byte_value, input byte_role, input param_index,
                  input frame_done, input frame_status, output ready);
endinterface

FILE: hdl/serial_frame_deframer_checksum.sv
// Each accepted byte's result beat is registered in the output register.
// Throughput: one byte per cycle while results are taken; the parser state and the
// output register both advance on every accepted beat, and a full output register is
// refilled in the same cycle that it is taken. Reset: parser hunts the first header
// byte, output empty, header and end-marker registers take their default values.
// -----------------------------------------------------------------------------
// Serial frame deframer with additive checksum
// Tags each received byte with its role and reports frame status on the last.
// -----------------------------------------------------------------------------
`include "serial_frame_deframer_checksum_defines.svh"

module serial_frame_deframer_checksum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sfd_rx_if.sink                        rx_i,
  sfd_res_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfd_pkg::ByteW-1:0]     cfg_data_i
);
  import sfd_pkg::*;

  logic [ByteW-1:0]   hdr1_q, hdr2_q, endm_q;
  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   len_q, len_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [ByteW-1:0]   sum_q, sum_d;
  logic               known_q, known_d;
  logic               match_q, match_d;

  logic               out_valid_q;
  logic [ByteW-1:0]   out_byte_q;
  role_e              out_role_q, role_d;
  logic [ByteW-1:0]   out_pidx_q, pidx_d;
  logic               out_done_q, done_d;
  status_e            out_status_q, status_d;

  logic               in_beat;
  logic [ByteW-1:0]   b;
  logic [PosW-1:0]    pos_inc;

  assign in_beat    = rx_i.valid && rx_i.ready;
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign b          = rx_i.rx_byte;
  assign pos_inc    = pos_q + PosW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q <= HdrFirstRst;
      hdr2_q <= HdrSecondRst;
      endm_q <= EndMarkRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HDR1: hdr1_q <= cfg_data_i;
        CFG_HDR2: hdr2_q <= cfg_data_i;
        CFG_END:  endm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    known_d  = known_q;
    match_d  = match_q;
    role_d   = ROLE_DISCARD;
    pidx_d   = '0;
    done_d   = 1'b0;
    status_d = ST_BUSY;
    unique case (phase_q)
      PH_HDR2: begin
        if (b == hdr2_q) begin
          role_d  = ROLE_HDR2;
          phase_d = PH_LEN;
        end else begin
          done_d   = 1'b1;
          status_d = ST_FORMAT;
          phase_d  = PH_HDR1;
        end
      end
      PH_LEN: begin
        role_d = ROLE_LEN;
        len_d  = b;
        sum_d  = b;
        pos_d  = '0;
        if (b < MinLength) begin
          done_d   = 1'b1;
          status_d = ST_FORMAT;
          phase_d  = PH_HDR1;
        end else begin
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        role_d  = ROLE_CMD;
        known_d = cmd_known(b);
        sum_d   = sum_q + b;
        phase_d = PH_FUNC;
      end
      PH_FUNC: begin
        role_d  = ROLE_FUNC;
        sum_d   = sum_q + b;
        phase_d = PH_CHAN;
      end
      PH_CHAN: begin
        role_d  = ROLE_CHAN;
        sum_d   = sum_q + b;
        pos_d   = '0;
        phase_d = (len_q == MinLength) ? PH_CSUM : PH_PARAM;
      end
      PH_PARAM: begin
        role_d = ROLE_PARAM;
        pidx_d = pos_q[ByteW-1:0];
        sum_d  = sum_q + b;
        pos_d  = pos_inc;
        if (pos_inc >= {1'b0, len_q - MinLength}) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        role_d  = ROLE_CSUM;
        match_d = (b == sum_q);
        phase_d = PH_END;
      end
      PH_END: begin
        role_d  = ROLE_END;
        done_d  = 1'b1;
        phase_d = PH_HDR1;
        priority if (b != endm_q) begin
          status_d = ST_FORMAT;
        end else if (!match_q) begin
          status_d = ST_CHECKSUM;
        end else if (!known_q) begin
          status_d = ST_UNKNOWN;
        end else begin
          status_d = ST_ACCEPT;
        end
      end
      default: begin
        if (b == hdr1_q) begin
          role_d  = ROLE_HDR1;
          phase_d = PH_HDR2;
        end else begin
          phase_d = PH_HDR1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR1;
      len_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
      known_q <= 1'b0;
      match_q <= 1'b0;
    end else if (in_beat) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      known_q <= known_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      out_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_byte_q   <= b;
      out_role_q   <= role_d;
      out_pidx_q   <= pidx_d;
      out_done_q   <= done_d;
      out_status_q <= status_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.byte_value   = out_byte_q;
  assign res_o.byte_role    = out_role_q;
  assign res_o.param_index  = out_pidx_q;
  assign res_o.frame_done   = out_done_q;
  assign res_o.frame_status = out_status_q;

  `SFDC_ASSERT(a_end_closes_frame, clk_i, rst_ni,
    (in_beat && phase_q == PH_END) |=> (out_valid_q && out_done_q && phase_q == PH_HDR1),
    "end-marker beat did not close the frame")
  `SFDC_ASSERT(a_param_exit, clk_i, rst_ni,
    (in_beat && phase_q == PH_PARAM) |=> (phase_q == PH_PARAM || phase_q == PH_CSUM),
    "parameter phase left to an unexpected phase")
  `SFDC_ASSERT(a_ready_when_empty, clk_i, rst_ni,
    !out_valid_q |-> rx_i.ready,
    "receive side stalled with an empty output register")
  `SFDC_ASSERT(a_status_on_done, clk_i, rst_ni,
    out_valid_q |-> (out_done_q == (out_status_q != ST_BUSY)),
    "frame status disagrees with frame done")

endmodule
